### rtl/core/ctg_pkg.sv
// Shared types, codes, constants and helper functions of the circle trajectory generator.
`timescale 1ns / 1ps
package ctg_pkg;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_ACCEL  = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DECEL  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		RM_ZERO  = 2'd0,
		RM_PROD  = 2'd1,
		RM_PEAK  = 2'd2,
		RM_CLAMP = 2'd3
	} rmode_t;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_UP   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DOWN = 4'd7;

	// CORDIC datapath width, Q30 with headroom.
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [28:0] TWO_PI_Q26 = 29'd421657428;
	localparam logic [22:0] SPEED_CAP = 23'd8388607;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// Round half up from Q30 and saturate to 24-bit signed.
	function automatic logic signed [23:0] sat_round(input logic signed [59:0] p);
		logic signed [59:0] r;
		logic signed [29:0] v;
		logic signed [23:0] o;
		r = p + 60'sd536870912;
		v = r[59:30];
		if (v > 30'sd8388607) begin
			o = 24'sd8388607;
		end else if (v < -30'sd8388608) begin
			o = -24'sd8388608;
		end else begin
			o = v[23:0];
		end
		return o;
	endfunction

endpackage

### rtl/core/ctg_if.sv
// Channel interfaces of the circle trajectory generator: item, result and configuration.
`timescale 1ns / 1ps
interface ctg_item_if;
	logic        valid;
	logic        ready;
	logic        running;
	logic [31:0] elapsed_time;
	modport source (output valid, running, elapsed_time, input ready);
	modport sink   (input valid, running, elapsed_time, output ready);
endinterface

interface ctg_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_y;
	logic [2:0]         motion_phase;
	modport source (output valid, pos_x, pos_y, vel_x, vel_y, motion_phase, input ready);
	modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, motion_phase, output ready);
endinterface

interface ctg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ctg_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/circle_trajectory_generator.sv
// An item moves from its transfer through the registered stages below to its result at the output register.
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// Profile terms that depend only on the registers settle through registered products, partials and angle
// terms, so the item channel is not ready after reset and after each register write until they settle.
// Reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
module circle_trajectory_generator #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ctg_item_if.sink      item,
	ctg_result_if.source  result,
	ctg_cfg_if.sink       cfg
);

	localparam int CW = ctg_pkg::CW;
	localparam logic [31:0] AMASK = 32'hFFFFFFFF << (32 - ANGLE_BITS);

	// Configuration registers.
	logic [22:0] radius_q;
	logic [31:0] start_q, hold_q, ru_q, cr_q, rd_q, au_q, ad_q;
	logic [1:0]  settle_q;

	// Derived profile terms.
	logic [63:0] peak_q, rusq_q;
	logic [32:0] end_cr_q;
	logic [33:0] end_dn_q;
	logic [63:0] hq0_q, lp0c_q;
	logic [32:0] hq1_q;
	logic [31:0] lp1c_q;
	logic [31:0] th_up_q, th_dn_q;

	logic adv;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 23'd131072;
			start_q  <= 32'd0;
			hold_q   <= 32'd3145728;
			ru_q     <= 32'd3145728;
			cr_q     <= 32'd14680064;
			rd_q     <= 32'd3145728;
			au_q     <= 32'd279620;
			ad_q     <= 32'd279620;
			settle_q <= 2'd3;
		end else begin
			if (cfg.valid) begin
				settle_q <= 2'd3;
				case (cfg.index)
					ctg_pkg::REG_RADIUS:     radius_q <= cfg.data[22:0];
					ctg_pkg::REG_START:      start_q  <= cfg.data;
					ctg_pkg::REG_HOLD:       hold_q   <= cfg.data;
					ctg_pkg::REG_RAMP_UP:    ru_q     <= cfg.data;
					ctg_pkg::REG_CRUISE:     cr_q     <= cfg.data;
					ctg_pkg::REG_RAMP_DOWN:  rd_q     <= cfg.data;
					ctg_pkg::REG_ACCEL_UP:   au_q     <= cfg.data;
					ctg_pkg::REG_ACCEL_DOWN: ad_q     <= cfg.data;
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// Register-only terms: peak rate, phase ends, angle at the end of ramp-up and of cruise.
	always_ff @(posedge clk) begin
		peak_q   <= {32'd0, au_q} * {32'd0, ru_q};
		rusq_q   <= {32'd0, ru_q} * {32'd0, ru_q};
		end_cr_q <= {1'b0, ru_q} + {1'b0, cr_q};
		end_dn_q <= {2'b00, ru_q} + {2'b00, cr_q} + {2'b00, rd_q};
		hq0_q    <= {32'd0, rusq_q[31:0]} * {32'd0, au_q};
		hq1_q    <= 33'({32'd0, rusq_q[63:32]} * {32'd0, au_q});
		lp0c_q   <= {32'd0, peak_q[31:0]} * {32'd0, cr_q};
		lp1c_q   <= 32'({32'd0, peak_q[63:32]} * {32'd0, cr_q});
	end

	logic [32:0] thu_sum;
	logic [31:0] thu_c;
	always_comb begin
		thu_sum = hq1_q + {1'b0, hq0_q[63:32]};
		thu_c   = thu_sum[32:1];
	end

	always_ff @(posedge clk) begin
		th_up_q <= thu_c;
		th_dn_q <= thu_c + lp1c_q + lp0c_q[63:32];
	end

	// Stage 1: time since the end of the hold.
	logic        vld_s1, act_s1;
	logic [31:0] mt_s1;

	assign item.ready = adv && (settle_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item.valid && item.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= item.running && (item.elapsed_time >= hold_q);
			mt_s1  <= item.elapsed_time - hold_q;
		end
	end

	// Stage 2: phase selection and operands of the angle and rate terms.
	logic             vld_s2, act_s2, qneg_s2;
	ctg_pkg::phase_t  phase_s2;
	ctg_pkg::rmode_t  rm_s2;
	logic [31:0]      dl_s2, dq_s2, aq_s2, base_s2, ra_s2, rb_s2;

	ctg_pkg::phase_t  ph_c;
	ctg_pkg::rmode_t  rm_c;
	logic             qneg_c;
	logic [31:0]      dl_c, dq_c, aq_c, base_c, ra_c, rb_c, dt_c;
	logic [33:0]      mt34;

	always_comb begin
		mt34   = {2'b00, mt_s1};
		dt_c   = mt_s1 - end_cr_q[31:0];
		ph_c   = ctg_pkg::PH_WAIT;
		rm_c   = ctg_pkg::RM_ZERO;
		qneg_c = 1'b0;
		dl_c   = 32'd0;
		dq_c   = 32'd0;
		aq_c   = au_q;
		base_c = 32'd0;
		ra_c   = au_q;
		rb_c   = 32'd0;
		if (act_s1) begin
			if (mt34 <= {2'b00, ru_q}) begin
				ph_c = ctg_pkg::PH_ACCEL;
				rm_c = ctg_pkg::RM_PROD;
				dq_c = mt_s1;
				rb_c = mt_s1;
			end else if (mt34 <= {1'b0, end_cr_q}) begin
				ph_c   = ctg_pkg::PH_CRUISE;
				rm_c   = ctg_pkg::RM_PEAK;
				dl_c   = mt_s1 - ru_q;
				base_c = th_up_q;
			end else if (mt34 <= end_dn_q) begin
				ph_c   = ctg_pkg::PH_DECEL;
				rm_c   = ctg_pkg::RM_CLAMP;
				qneg_c = 1'b1;
				dl_c   = dt_c;
				dq_c   = dt_c;
				aq_c   = ad_q;
				base_c = th_dn_q;
				ra_c   = ad_q;
				rb_c   = dt_c;
			end else begin
				ph_c   = ctg_pkg::PH_DONE;
				qneg_c = 1'b1;
				dl_c   = rd_q;
				dq_c   = rd_q;
				aq_c   = ad_q;
				base_c = th_dn_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2   <= act_s1;
			phase_s2 <= ph_c;
			rm_s2    <= rm_c;
			qneg_s2  <= qneg_c;
			dl_s2    <= dl_c;
			dq_s2    <= dq_c;
			aq_s2    <= aq_c;
			base_s2  <= base_c;
			ra_s2    <= ra_c;
			rb_s2    <= rb_c;
		end
	end

	// Stage 3: square of the quadratic time, rate product, linear-term partials.
	logic             vld_s3, act_s3, qneg_s3;
	ctg_pkg::phase_t  phase_s3;
	ctg_pkg::rmode_t  rm_s3;
	logic [63:0]      tsq_s3, rp_s3, lp0_s3;
	logic [31:0]      lp1_s3, aq_s3, base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s3   <= act_s2;
			qneg_s3  <= qneg_s2;
			phase_s3 <= phase_s2;
			rm_s3    <= rm_s2;
			tsq_s3   <= {32'd0, dq_s2} * {32'd0, dq_s2};
			rp_s3    <= {32'd0, ra_s2} * {32'd0, rb_s2};
			lp0_s3   <= {32'd0, peak_q[31:0]} * {32'd0, dl_s2};
			lp1_s3   <= 32'({32'd0, peak_q[63:32]} * {32'd0, dl_s2});
			aq_s3    <= aq_s2;
			base_s3  <= base_s2;
		end
	end

	// Stage 4: quadratic-term partials, base plus linear term, angular rate.
	logic             vld_s4, act_s4, qneg_s4;
	ctg_pkg::phase_t  phase_s4;
	logic [63:0]      q0_s4, rate_s4;
	logic [32:0]      q1_s4;
	logic [31:0]      bl_s4;
	logic [63:0]      rate_c;

	always_comb begin
		case (rm_s3)
			ctg_pkg::RM_PROD:  rate_c = rp_s3;
			ctg_pkg::RM_PEAK:  rate_c = peak_q;
			ctg_pkg::RM_CLAMP: rate_c = (rp_s3 >= peak_q) ? 64'd0 : peak_q - rp_s3;
			default:           rate_c = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4   <= act_s3;
			qneg_s4  <= qneg_s3;
			phase_s4 <= phase_s3;
			q0_s4    <= {32'd0, tsq_s3[31:0]} * {32'd0, aq_s3};
			q1_s4    <= 33'({32'd0, tsq_s3[63:32]} * {32'd0, aq_s3});
			bl_s4    <= base_s3 + lp1_s3 + lp0_s3[63:32];
			rate_s4  <= rate_c;
		end
	end

	// Stage 5: final angle, speed partials.
	logic             vld_s5;
	ctg_pkg::phase_t  phase_s5;
	logic [31:0]      angle_s5;
	logic [54:0]      pr0_s5, pr1_s5;
	logic [32:0]      quad_sum;
	logic [31:0]      theta_c;

	always_comb begin
		quad_sum = q1_s4 + {1'b0, q0_s4[63:32]};
		theta_c  = qneg_s4 ? bl_s4 - quad_sum[32:1] : bl_s4 + quad_sum[32:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s5 <= phase_s4;
			angle_s5 <= act_s4 ? theta_c + start_q : start_q;
			pr0_s5   <= {23'd0, rate_s4[31:0]} * {32'd0, radius_q};
			pr1_s5   <= {23'd0, rate_s4[63:32]} * {32'd0, radius_q};
		end
	end

	// Stage 6: rate times radius, quadrant fold of the angle.
	logic             vld_s6, cap_s6, flip_s6;
	ctg_pkg::phase_t  phase_s6;
	logic [33:0]      prl_s6;
	logic signed [CW-1:0] z_s6;
	logic [55:0]      pr_c;
	logic [31:0]      am_c, aq4_c, af_c;

	always_comb begin
		pr_c  = {1'b0, pr1_s5} + {33'd0, pr0_s5[54:32]};
		am_c  = angle_s5 & AMASK;
		aq4_c = am_c + 32'h40000000;
		af_c  = aq4_c[31] ? am_c + 32'h80000000 : am_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s6 <= phase_s5;
			cap_s6   <= |pr_c[55:34];
			prl_s6   <= pr_c[33:0];
			flip_s6  <= aq4_c[31];
			z_s6     <= CW'($signed(af_c));
		end
	end

	// Stage 7: scale by two pi.
	logic             vld_s7, cap_s7, flip_s7;
	ctg_pkg::phase_t  phase_s7;
	logic [62:0]      sp_s7;
	logic signed [CW-1:0] z_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s7 <= phase_s6;
			cap_s7   <= cap_s6;
			flip_s7  <= flip_s6;
			z_s7     <= z_s6;
			sp_s7    <= {29'd0, prl_s6} * {34'd0, ctg_pkg::TWO_PI_Q26};
		end
	end

	// Stage 8: round and saturate the speed.
	logic             vld_s8, flip_s8;
	ctg_pkg::phase_t  phase_s8;
	logic [22:0]      speed_s8;
	logic signed [CW-1:0] z_s8;
	logic [63:0]      spr_c;

	always_comb begin
		spr_c = {1'b0, sp_s7} + 64'd137438953472;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s8 <= phase_s7;
			flip_s8  <= flip_s7;
			z_s8     <= z_s7;
			speed_s8 <= (cap_s7 || (|spr_c[63:61])) ? ctg_pkg::SPEED_CAP : spr_c[60:38];
		end
	end

	// CORDIC rotation, one micro-rotation per stage.
	logic                 cvld_s9 [CORDIC_STEPS];
	logic signed [CW-1:0] cx_s9   [CORDIC_STEPS];
	logic signed [CW-1:0] cy_s9   [CORDIC_STEPS];
	logic signed [CW-1:0] cz_s9   [CORDIC_STEPS];
	logic                 cf_s9   [CORDIC_STEPS];
	logic [22:0]          csp_s9  [CORDIC_STEPS];
	ctg_pkg::phase_t      cph_s9  [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		localparam logic signed [CW-1:0] ATAN_K = CW'(ctg_pkg::atan_turn(k));
		logic                 vi, fi;
		logic signed [CW-1:0] xi, yi, zi, dx, dy;
		logic [22:0]          spi;
		ctg_pkg::phase_t      phi;

		if (k == 0) begin : g_first
			always_comb begin
				vi  = vld_s8;
				xi  = ctg_pkg::CORDIC_GAIN_Q30;
				yi  = '0;
				zi  = z_s8;
				fi  = flip_s8;
				spi = speed_s8;
				phi = phase_s8;
			end
		end else begin : g_next
			always_comb begin
				vi  = cvld_s9[k-1];
				xi  = cx_s9[k-1];
				yi  = cy_s9[k-1];
				zi  = cz_s9[k-1];
				fi  = cf_s9[k-1];
				spi = csp_s9[k-1];
				phi = cph_s9[k-1];
			end
		end

		assign dx = yi >>> k;
		assign dy = xi >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s9[k] <= 1'b0;
			end else if (adv) begin
				cvld_s9[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (zi >= 0) begin
					cx_s9[k] <= xi - dx;
					cy_s9[k] <= yi + dy;
					cz_s9[k] <= zi - ATAN_K;
				end else begin
					cx_s9[k] <= xi + dx;
					cy_s9[k] <= yi - dy;
					cz_s9[k] <= zi + ATAN_K;
				end
				cf_s9[k]  <= fi;
				csp_s9[k] <= spi;
				cph_s9[k] <= phi;
			end
		end
	end

	// Stage 10: amplitude products.
	localparam int LS = CORDIC_STEPS - 1;
	logic                 vld_s10;
	ctg_pkg::phase_t      phase_s10;
	logic signed [59:0]   mx_s10, my_s10, mvx_s10, mvy_s10;
	logic signed [CW:0]   c_c, s_c;
	logic signed [24:0]   rad_c, spd_c, nspd_c;

	always_comb begin
		c_c    = cf_s9[LS] ? -(CW+1)'(cx_s9[LS]) : (CW+1)'(cx_s9[LS]);
		s_c    = cf_s9[LS] ? -(CW+1)'(cy_s9[LS]) : (CW+1)'(cy_s9[LS]);
		rad_c  = $signed({2'b00, radius_q});
		spd_c  = $signed({2'b00, csp_s9[LS]});
		nspd_c = -spd_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s10 <= cvld_s9[LS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s10 <= cph_s9[LS];
			mx_s10    <= rad_c * c_c;
			my_s10    <= rad_c * s_c;
			mvx_s10   <= nspd_c * s_c;
			mvy_s10   <= spd_c * c_c;
		end
	end

	// Stage 11: output register, rounded and saturated.
	logic                 vld_s11;
	ctg_pkg::phase_t      phase_s11;
	logic signed [23:0]   px_s11, py_s11, vx_s11, vy_s11;

	assign adv = !vld_s11 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s11 <= phase_s10;
			px_s11    <= ctg_pkg::sat_round(mx_s10);
			py_s11    <= ctg_pkg::sat_round(my_s10);
			vx_s11    <= ctg_pkg::sat_round(mvx_s10);
			vy_s11    <= ctg_pkg::sat_round(mvy_s10);
		end
	end

	assign result.valid        = vld_s11;
	assign result.pos_x        = px_s11;
	assign result.pos_y        = py_s11;
	assign result.vel_x        = vx_s11;
	assign result.vel_y        = vy_s11;
	assign result.motion_phase = phase_s11;

endmodule
